// File: sv/gain_split_analog_digital_assert.svh
// Assertion macros shared by the gain splitter modules.
`ifndef GAIN_SPLIT_ANALOG_DIGITAL_ASSERT_SVH
`define GAIN_SPLIT_ANALOG_DIGITAL_ASSERT_SVH

`ifndef SYNTHESIS

`define GSAD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`define GSAD_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`define GSAD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define GSAD_ASSERT(lbl, prop, msg)
`define GSAD_ASSERT_IMPLY(lbl, ante, cons, msg)
`define GSAD_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// File: sv/gsad_pkg.sv
// Types, constants and step tables of the gain splitter.
`timescale 1ns / 1ps

package gsad_pkg;

  localparam int GAIN_W   = 16;
  localparam int CODE_W   = 4;
  localparam int DG_W     = 12;
  localparam int SCALED_W = 23;
  localparam int HUND_W   = 11;
  localparam int RECIP_W  = 26;
  localparam int PROD_W   = SCALED_W + RECIP_W;
  localparam int Q_W      = 16;
  localparam int QH_W     = Q_W + HUND_W;
  localparam int STEP_COUNT = 16;

  localparam logic [DG_W-1:0] DG_MAX = 12'd4095;
  localparam logic [DG_W-1:0] DG_MIN = 12'd1;
  localparam logic [SCALED_W-1:0] SCALED_STEP1 = 23'd30720;

  typedef logic [CODE_W-1:0] code_t;

  typedef struct packed {
    code_t                 code;
    logic [SCALED_W-1:0]   scaled;
  } sel_t;

  typedef struct packed {
    code_t                 code;
    logic [SCALED_W-1:0]   scaled;
    logic [Q_W-1:0]        q0;
  } est_t;

  typedef struct packed {
    code_t                 code;
    logic [SCALED_W-1:0]   scaled;
    logic [Q_W-1:0]        q0;
    logic [SCALED_W-1:0]   qh;
  } prod_t;

  function automatic logic [HUND_W-1:0] step_hundredths(input code_t code);
    logic [HUND_W-1:0] h;
    case (code)
      4'd0:    h = 11'd100;
      4'd1:    h = 11'd120;
      4'd2:    h = 11'd145;
      4'd3:    h = 11'd171;
      4'd4:    h = 11'd200;
      4'd5:    h = 11'd240;
      4'd6:    h = 11'd300;
      4'd7:    h = 11'd343;
      4'd8:    h = 11'd400;
      4'd9:    h = 11'd480;
      4'd10:   h = 11'd600;
      4'd11:   h = 11'd686;
      4'd12:   h = 11'd800;
      4'd13:   h = 11'd960;
      4'd14:   h = 11'd1200;
      default: h = 11'd1600;
    endcase
    return h;
  endfunction

  // floor(2**32 / hundredths) for each step.
  function automatic logic [RECIP_W-1:0] step_recip(input code_t code);
    logic [RECIP_W-1:0] r;
    case (code)
      4'd0:    r = 26'd42949672;
      4'd1:    r = 26'd35791394;
      4'd2:    r = 26'd29620464;
      4'd3:    r = 26'd25116767;
      4'd4:    r = 26'd21474836;
      4'd5:    r = 26'd17895697;
      4'd6:    r = 26'd14316557;
      4'd7:    r = 26'd12521770;
      4'd8:    r = 26'd10737418;
      4'd9:    r = 26'd8947848;
      4'd10:   r = 26'd7158278;
      4'd11:   r = 26'd6260885;
      4'd12:   r = 26'd5368709;
      4'd13:   r = 26'd4473924;
      4'd14:   r = 26'd3579139;
      default: r = 26'd2684354;
    endcase
    return r;
  endfunction

endpackage

// File: sv/gsad_stream_if.sv
// Valid/ready channel interfaces for gain requests and gain splits.
`timescale 1ns / 1ps

interface gsad_in_if;
  logic                         valid;
  logic                         ready;
  logic [gsad_pkg::GAIN_W-1:0]  total_gain;

  modport source (output valid, output total_gain, input ready);
  modport sink   (input valid, input total_gain, output ready);
endinterface

interface gsad_out_if;
  logic                         valid;
  logic                         ready;
  gsad_pkg::code_t              analog_code;
  logic [gsad_pkg::DG_W-1:0]    digital_gain;
  logic                         clamped;

  modport source (output valid, output analog_code, output digital_gain,
                  output clamped, input ready);
  modport sink   (input valid, input analog_code, input digital_gain,
                  input clamped, output ready);
endinterface

// File: sv/gsad_select.sv
// First stage: scales the request by 100 and picks the analog step.
`timescale 1ns / 1ps
`include "gain_split_analog_digital_assert.svh"

module gsad_select (
  input  logic           clk,
  input  logic           rst_n,
  gsad_in_if.sink        in_chan,
  output logic           valid_o,
  input  logic           ready_i,
  output gsad_pkg::sel_t data_o
);

  logic           v_r;
  gsad_pkg::sel_t s_r;
  gsad_pkg::sel_t s_nxt;
  logic           adv;

  assign adv = !v_r || ready_i;
  assign in_chan.ready = adv;

  always_comb begin
    logic [gsad_pkg::SCALED_W-1:0] sc;
    sc = ({7'b0, in_chan.total_gain} << 6) + ({7'b0, in_chan.total_gain} << 5)
       + ({7'b0, in_chan.total_gain} << 2);
    s_nxt.scaled = sc;
    s_nxt.code   = '0;
    for (int k = 1; k < gsad_pkg::STEP_COUNT; k++) begin
      if (sc >= gsad_pkg::SCALED_W'({gsad_pkg::step_hundredths(gsad_pkg::CODE_W'(k)), 8'b0}))
      begin
        s_nxt.code = gsad_pkg::CODE_W'(k);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (adv) begin
      v_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && in_chan.valid) begin
      s_r <= s_nxt;
    end
  end

  assign valid_o = v_r;
  assign data_o  = s_r;

  `GSAD_ASSERT_IMPLY(a_step0_below_threshold, v_r,
    (s_r.code == '0) == (s_r.scaled < gsad_pkg::SCALED_STEP1),
    "Step zero chosen inconsistently with the first threshold.")

  `GSAD_ASSERT_NEXT(a_stall_holds, v_r && !ready_i, v_r && $stable(s_r),
    "Selection stage changed while stalled.")

endmodule

// File: sv/gsad_recip.sv
// Second stage: quotient estimate by multiplication with the step reciprocal.
`timescale 1ns / 1ps

module gsad_recip (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           valid_i,
  output logic           ready_o,
  input  gsad_pkg::sel_t data_i,
  output logic           valid_o,
  input  logic           ready_i,
  output gsad_pkg::est_t data_o
);

  logic           v_r;
  gsad_pkg::est_t e_r;
  gsad_pkg::est_t e_nxt;
  logic [gsad_pkg::PROD_W-1:0] prod;

  assign ready_o = !v_r || ready_i;

  assign prod = {{gsad_pkg::RECIP_W{1'b0}}, data_i.scaled}
              * {{gsad_pkg::SCALED_W{1'b0}}, gsad_pkg::step_recip(data_i.code)};

  always_comb begin
    e_nxt.code   = data_i.code;
    e_nxt.scaled = data_i.scaled;
    e_nxt.q0     = prod[32 +: gsad_pkg::Q_W];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (ready_o) begin
      v_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && valid_i) begin
      e_r <= e_nxt;
    end
  end

  assign valid_o = v_r;
  assign data_o  = e_r;

endmodule

// File: sv/gsad_fixup.sv
// Third and fourth stages: back-multiply, quotient correction and clamping.
`timescale 1ns / 1ps
`include "gain_split_analog_digital_assert.svh"

module gsad_fixup (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           valid_i,
  output logic           ready_o,
  input  gsad_pkg::est_t data_i,
  gsad_out_if.source     out_chan
);

  logic            v3_r;
  logic            v4_r;
  gsad_pkg::prod_t p_r;
  gsad_pkg::prod_t p_nxt;
  logic            adv3;
  logic            adv4;
  logic [gsad_pkg::QH_W-1:0] qh_full;

  gsad_pkg::code_t           code_r;
  logic [gsad_pkg::DG_W-1:0] dg_r;
  logic                      clip_r;
  logic [gsad_pkg::DG_W-1:0] dg_nxt;
  logic                      clip_nxt;

  assign adv4    = !v4_r || out_chan.ready;
  assign adv3    = !v3_r || adv4;
  assign ready_o = adv3;

  assign qh_full = {{gsad_pkg::HUND_W{1'b0}}, data_i.q0}
                 * {{gsad_pkg::Q_W{1'b0}}, gsad_pkg::step_hundredths(data_i.code)};

  always_comb begin
    p_nxt.code   = data_i.code;
    p_nxt.scaled = data_i.scaled;
    p_nxt.q0     = data_i.q0;
    p_nxt.qh     = qh_full[gsad_pkg::SCALED_W-1:0];
  end

  // The estimate is the true quotient or one below it.
  always_comb begin
    logic [gsad_pkg::SCALED_W-1:0] rem;
    logic [gsad_pkg::Q_W-1:0]      q;
    rem = p_r.scaled - p_r.qh;
    q   = p_r.q0;
    if (rem >= gsad_pkg::SCALED_W'(gsad_pkg::step_hundredths(p_r.code))) begin
      q = p_r.q0 + 16'd1;
    end
    if (q > gsad_pkg::Q_W'(gsad_pkg::DG_MAX)) begin
      dg_nxt   = gsad_pkg::DG_MAX;
      clip_nxt = 1'b1;
    end else if (q < gsad_pkg::Q_W'(gsad_pkg::DG_MIN)) begin
      dg_nxt   = gsad_pkg::DG_MIN;
      clip_nxt = 1'b1;
    end else begin
      dg_nxt   = q[gsad_pkg::DG_W-1:0];
      clip_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (adv3) begin
        v3_r <= valid_i;
      end
      if (adv4) begin
        v4_r <= v3_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv3 && valid_i) begin
      p_r <= p_nxt;
    end
    if (adv4 && v3_r) begin
      code_r <= p_r.code;
      dg_r   <= dg_nxt;
      clip_r <= clip_nxt;
    end
  end

  assign out_chan.valid        = v4_r;
  assign out_chan.analog_code  = code_r;
  assign out_chan.digital_gain = dg_r;
  assign out_chan.clamped      = clip_r;

  `GSAD_ASSERT_IMPLY(a_backmul_not_above, v3_r, p_r.qh <= p_r.scaled,
    "Quotient estimate exceeds the true quotient.")

  `GSAD_ASSERT_IMPLY(a_gain_nonzero, v4_r, dg_r != '0,
    "Digital gain of zero presented.")

  `GSAD_ASSERT_IMPLY(a_clamp_value, v4_r && clip_r,
    (dg_r == gsad_pkg::DG_MIN) || (dg_r == gsad_pkg::DG_MAX),
    "Clamp flag set on an unclamped digital gain.")

endmodule

// File: sv/gain_split_analog_digital.sv
// Top level of the gain splitter: analog step selection and digital gain.
`timescale 1ns / 1ps

// Splits a requested total gain (8 fraction bits) into the largest analog step
// not above it and the remaining digital gain, clamped to 1..4095. One transfer
// is taken every cycle while the output is not stalled. Each result passes the
// step compare, the reciprocal multiply that estimates the quotient, the
// back-multiply by the step, and the one-step correction with clamping, which
// each take one register stage. A stall at the output holds every stage in
// place, and empty stages keep accepting requests.
module gain_split_analog_digital (
  input  logic       clk,
  input  logic       rst_n,
  gsad_in_if.sink    in_chan,
  gsad_out_if.source out_chan
);

  logic           sel_valid;
  logic           sel_ready;
  gsad_pkg::sel_t sel_data;
  logic           est_valid;
  logic           est_ready;
  gsad_pkg::est_t est_data;

  gsad_select u_select (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .valid_o (sel_valid),
    .ready_i (sel_ready),
    .data_o  (sel_data)
  );

  gsad_recip u_recip (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (sel_valid),
    .ready_o (sel_ready),
    .data_i  (sel_data),
    .valid_o (est_valid),
    .ready_i (est_ready),
    .data_o  (est_data)
  );

  gsad_fixup u_fixup (
    .clk      (clk),
    .rst_n    (rst_n),
    .valid_i  (est_valid),
    .ready_o  (est_ready),
    .data_i   (est_data),
    .out_chan (out_chan)
  );

endmodule

// File: dv/testbench.sv
// Self-checking testbench of the gain splitter: directed, threshold and random requests.
`timescale 1ns / 1ps

module testbench;

  typedef struct packed {
    gsad_pkg::code_t             analog_code;
    logic [gsad_pkg::DG_W-1:0]   digital_gain;
    logic                        clamped;
  } gain_split_t;

  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_LIMIT = 5000;
  localparam int PIPE_DEPTH  = 4;

  logic clk = 1'b0;
  logic rst_n;

  gsad_in_if  in_bus ();
  gsad_out_if out_bus ();

  gain_split_analog_digital u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_bus),
    .out_chan (out_bus)
  );

  gain_split_t split_queue[$];
  gain_split_t want_split;
  int          errors;
  int          requests_sent;
  int          splits_checked;
  int          clamps_seen;
  logic [15:0] codes_seen;
  int          cycles;
  bit          idle_on;
  int          stall_left;

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d splits outstanding", $time, split_queue.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic int unsigned analog_step_x100(input int unsigned code);
    case (code)
      0:       return 100;
      1:       return 120;
      2:       return 145;
      3:       return 171;
      4:       return 200;
      5:       return 240;
      6:       return 300;
      7:       return 343;
      8:       return 400;
      9:       return 480;
      10:      return 600;
      11:      return 686;
      12:      return 800;
      13:      return 960;
      14:      return 1200;
      default: return 1600;
    endcase
  endfunction

  // Smallest request that selects the given step.
  function automatic int unsigned step_threshold(input int unsigned code);
    return (analog_step_x100(code) * 256 + 99) / 100;
  endfunction

  function automatic gain_split_t split_gain(input logic [15:0] gain);
    gain_split_t  res;
    int unsigned  scaled;
    int unsigned  quot;
    int unsigned  pick;
    scaled = int'(gain) * 100;
    pick = 0;
    for (int k = 1; k < 16; k++) begin
      if (scaled >= analog_step_x100(k) * 256) pick = k;
    end
    quot = scaled / analog_step_x100(pick);
    res.analog_code = pick[3:0];
    res.clamped = 1'b0;
    if (quot > 4095) begin
      quot = 4095;
      res.clamped = 1'b1;
    end
    if (quot < 1) begin
      quot = 1;
      res.clamped = 1'b1;
    end
    res.digital_gain = quot[11:0];
    return res;
  endfunction

  task automatic send_gain(input logic [15:0] gain);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_bus.valid      <= 1'b1;
    in_bus.total_gain <= gain;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    split_queue.push_back(split_gain(gain));
    requests_sent++;
  endtask

  task automatic wait_for_splits();
    in_bus.valid <= 1'b0;
    @(posedge clk);
    for (int i = 0; i < DRAIN_LIMIT && split_queue.size() != 0; i++) @(posedge clk);
  endtask

  function automatic logic [15:0] gain_near_step();
    int g;
    g = int'(step_threshold($urandom_range(1, 15))) + $urandom_range(0, 6) - 3;
    return g[15:0];
  endfunction

  task automatic test_directed();
    send_gain(16'd0);
    send_gain(16'd1);
    send_gain(16'd255);
    send_gain(16'd256);
    send_gain(16'd306);
    send_gain(16'd307);
    send_gain(16'd308);
    send_gain(16'd4095);
    send_gain(16'd4096);
    send_gain(16'hFFFF);
    send_gain(16'hFFFE);
    send_gain(16'h5555);
    send_gain(16'hAAAA);
    for (int k = 1; k < 16; k++) begin
      if (k == 2 || k == 7 || k == 11 || k == 14) begin
        send_gain(16'(step_threshold(k) - 1));
        send_gain(16'(step_threshold(k)));
      end
    end
  endtask

  task automatic test_step_edges(input int count);
    for (int i = 0; i < count; i++) send_gain(gain_near_step());
  endtask

  task automatic test_mixed_random(input int count);
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 3))
        0:       send_gain(16'($urandom_range(0, 511)));
        1:       send_gain(16'($urandom_range(0, 8191)));
        2:       send_gain(gain_near_step());
        default: send_gain(16'($urandom));
      endcase
    end
  endtask

  task automatic test_drain_pause(input int count);
    test_mixed_random(count);
    wait_for_splits();
    test_mixed_random(count);
  endtask

  task automatic test_full_rate(input int count);
    idle_on = 1'b0;
    test_mixed_random(count);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (stall_left == 0 && idle_on && $urandom_range(0, 7) == 0)
        stall_left = $urandom_range(1, 11);
      if (stall_left > 0) begin
        out_bus.ready <= 1'b0;
        stall_left--;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (split_queue.size() == 0) begin
        errors++;
        $display("%0t: unexpected split: expected none, actual code %0d gain %0d clamped %0b",
                 $time, out_bus.analog_code, out_bus.digital_gain, out_bus.clamped);
      end else begin
        want_split = split_queue.pop_front();
        splits_checked++;
        codes_seen[out_bus.analog_code] = 1'b1;
        if (out_bus.clamped === 1'b1) clamps_seen++;
        if (out_bus.analog_code !== want_split.analog_code) begin
          errors++;
          $display("%0t: analog_code mismatch: expected %0d, actual %0d",
                   $time, want_split.analog_code, out_bus.analog_code);
        end
        if (out_bus.digital_gain !== want_split.digital_gain) begin
          errors++;
          $display("%0t: digital_gain mismatch: expected %0d, actual %0d",
                   $time, want_split.digital_gain, out_bus.digital_gain);
        end
        if (out_bus.clamped !== want_split.clamped) begin
          errors++;
          $display("%0t: clamped mismatch: expected %0b, actual %0b",
                   $time, want_split.clamped, out_bus.clamped);
        end
      end
    end
  end

  initial begin
    rst_n             = 1'b0;
    in_bus.valid      = 1'b0;
    in_bus.total_gain = '0;
    idle_on           = 1'b1;
    codes_seen        = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_step_edges(200);
    test_mixed_random(150);
    test_drain_pause(75);
    idle_on = 1'b0;
    test_mixed_random(40);
    idle_on = 1'b1;
    test_mixed_random(40);
    test_full_rate(180);

    wait_for_splits();
    repeat (PIPE_DEPTH * 3) @(posedge clk);
    if (split_queue.size() != 0) begin
      errors += split_queue.size();
      $display("%0t: %0d expected splits never arrived", $time, split_queue.size());
    end

    $display("Sent %0d gain requests and checked %0d splits, %0d of them clamped.",
             requests_sent, splits_checked, clamps_seen);
    $display("Analog step codes observed (bit mask): %04h", codes_seen);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
